>>> rtl/mrbm_pkg.sv
`timescale 1ns / 1ps

package mrbm_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_COLS_DEF = 64;
    localparam int MAX_ROWS_DEF = 256;

    // Fixed field widths
    localparam int CFG_W  = 7;
    localparam int AREA_W = 15;

    localparam logic [CFG_W-1:0]  NUM_COLUMNS_RST = 7'd64;
    localparam logic [AREA_W-1:0] AREA_CAP        = 15'h7FFF;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CELL,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_SCAN_POP,
        ST_OUT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic clr_step;    // zero one height entry
        logic cell_take;   // latch the item, read its column height
        logic cell_upd;    // write back the new column height
        logic scan_start;  // close the row, set up the histogram scan
        logic scan_rd;     // read the height of the current slot
        logic push;        // push top of stack, current slot becomes top
        logic pop_start;   // read the entry below the top
        logic pop_load;    // entry below becomes top, form the area
        logic out_load;    // load the result register, clear best area
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clr_done;    // last entry of the clearing sweep
        logic row_close;   // the current cell closes its row
        logic last;        // the current cell ends the matrix
        logic less;        // current slot height below top of stack
        logic final_slot;  // current slot is the right-hand sentinel
        logic out_free;    // result register can take a new result
    } sts_t;

endpackage

>>> rtl/maximal_rectangle_binary_matrix.sv
`timescale 1ns / 1ps

// Largest all-ones rectangle of a binary matrix streamed in row-major order.
// Input channel (s_*): one cell per item; s_tdata bit 0 is the cell, s_tlast
// marks the last cell of the matrix. Output channel (m_*): one item per
// matrix, the area in m_tdata[14:0], given after the last cell.
// cfg_wen/cfg_wdata write the column count (0 acts as 1, large values clamp
// to MAX_COLS); write it only between items.
// Each cell reads and then writes back its column height; no new cell is
// taken until that and any scan it starts are done. A cell that closes a
// row starts a histogram scan over its n columns (n+1 slots with the right
// sentinel): each pop reads the entry below the top and forms an area. After
// the last cell the result is loaded into the output register, then a
// clearing sweep zeroes all MAX_COLS height entries before the next cell.
// Reset: the same clearing sweep runs before s_tready first rises.
// Stall: the result waits in the output register while the next matrix is
// taken; only a second result held back by a stalled receiver waits.
module maximal_rectangle_binary_matrix
#(
    parameter int MAX_COLS = mrbm_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = mrbm_pkg::MAX_ROWS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wen,
    input  logic [mrbm_pkg::CFG_W-1:0] cfg_wdata,    // num_columns
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,      // [0] cell_bit, [7:1] zero
    input  logic                       s_tlast,      // matrix_end
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [15:0]                m_tdata       // [14:0] max_area, [15] zero
);

    mrbm_pkg::cmd_t              cmd;
    mrbm_pkg::sts_t              sts;
    logic [mrbm_pkg::AREA_W-1:0] area;

    // Sequencer: clearing sweep, cell update, histogram scan, result hand-off
    mrbm_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Height memory, scan stack, area multiplier and result register
    mrbm_dpath
    #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    )
    u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .in_bit    (s_tdata[0]),
        .in_last   (s_tlast),
        .m_tready  (m_tready),
        .out_vld   (m_tvalid),
        .out_area  (area),
        .cmd       (cmd),
        .sts       (sts)
    );

    // Pad the area to a whole byte count
    assign m_tdata = {1'b0, area};

endmodule

>>> rtl/mrbm_ctrl.sv
`timescale 1ns / 1ps

module mrbm_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  mrbm_pkg::sts_t    sts,
    output mrbm_pkg::cmd_t    cmd
);

    mrbm_pkg::state_t state_reg;
    mrbm_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mrbm_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mrbm_pkg::ST_CLEAR:
            begin
                if (sts.clr_done)
                begin
                    state_next = mrbm_pkg::ST_IDLE;
                end
            end
            mrbm_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = mrbm_pkg::ST_CELL;
                end
            end
            mrbm_pkg::ST_CELL:
            begin
                state_next = sts.row_close ? mrbm_pkg::ST_SCAN_RD : mrbm_pkg::ST_IDLE;
            end
            mrbm_pkg::ST_SCAN_RD:
            begin
                state_next = mrbm_pkg::ST_SCAN_CMP;
            end
            mrbm_pkg::ST_SCAN_CMP:
            begin
                if (sts.less)
                begin
                    state_next = mrbm_pkg::ST_SCAN_POP;
                end
                else if (sts.final_slot)
                begin
                    state_next = sts.last ? mrbm_pkg::ST_OUT : mrbm_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = mrbm_pkg::ST_SCAN_RD;
                end
            end
            mrbm_pkg::ST_SCAN_POP:
            begin
                state_next = mrbm_pkg::ST_SCAN_CMP;
            end
            mrbm_pkg::ST_OUT:
            begin
                if (sts.out_free)
                begin
                    state_next = mrbm_pkg::ST_CLEAR;
                end
            end
            default:
            begin
                state_next = mrbm_pkg::ST_CLEAR;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            mrbm_pkg::ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
            end
            mrbm_pkg::ST_IDLE:
            begin
                s_tready      = 1'b1;
                cmd.cell_take = s_tvalid;
            end
            mrbm_pkg::ST_CELL:
            begin
                cmd.cell_upd   = 1'b1;
                cmd.scan_start = sts.row_close;
            end
            mrbm_pkg::ST_SCAN_RD:
            begin
                cmd.scan_rd = 1'b1;
            end
            mrbm_pkg::ST_SCAN_CMP:
            begin
                cmd.pop_start = sts.less;
                cmd.push      = !sts.less && !sts.final_slot;
            end
            mrbm_pkg::ST_SCAN_POP:
            begin
                cmd.pop_load = 1'b1;
            end
            mrbm_pkg::ST_OUT:
            begin
                cmd.out_load = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> rtl/mrbm_dpath.sv
`timescale 1ns / 1ps

module mrbm_dpath
#(
    parameter int MAX_COLS = mrbm_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = mrbm_pkg::MAX_ROWS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wen,
    input  logic [mrbm_pkg::CFG_W-1:0]  cfg_wdata,
    input  logic                        in_bit,
    input  logic                        in_last,
    input  logic                        m_tready,
    output logic                        out_vld,
    output logic [mrbm_pkg::AREA_W-1:0] out_area,
    input  mrbm_pkg::cmd_t              cmd,
    output mrbm_pkg::sts_t              sts
);

    localparam int ADDR_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int SLOT_W = $clog2(MAX_COLS + 2);
    localparam int HW     = $clog2(MAX_ROWS + 1);
    localparam int CMP_W  = (SLOT_W > mrbm_pkg::CFG_W) ? SLOT_W : mrbm_pkg::CFG_W;
    localparam int PROD_W = HW + SLOT_W;
    localparam int CAP_W  = (PROD_W > mrbm_pkg::AREA_W) ? PROD_W : mrbm_pkg::AREA_W;

    typedef struct packed {
        logic [SLOT_W-1:0] idx;
        logic [HW-1:0]     h;
    } stk_ent_t;

    // Column heights and scan stack
    logic [HW-1:0] hmem [MAX_COLS];
    stk_ent_t      smem [MAX_COLS];

    logic [HW-1:0]               h_rdata_reg;
    stk_ent_t                    s_rdata_reg;
    logic [mrbm_pkg::CFG_W-1:0]  cols_reg;
    logic [ADDR_W-1:0]           pos_reg;
    logic [ADDR_W-1:0]           clr_cnt_reg;
    logic                        bit_reg;
    logic                        last_reg;
    logic [SLOT_W-1:0]           n_reg;
    logic [SLOT_W-1:0]           i_reg;
    logic [SLOT_W-1:0]           sp_reg;
    stk_ent_t                    top_reg;
    logic [HW-1:0]               peak_h_reg;
    logic [PROD_W-1:0]           prod_reg;
    logic                        prod_vld_reg;
    logic [mrbm_pkg::AREA_W-1:0] best_reg;
    logic                        out_vld_reg;
    logic [mrbm_pkg::AREA_W-1:0] out_area_reg;

    logic                        h_we;
    logic [ADDR_W-1:0]           h_waddr;
    logic [HW-1:0]               h_wdata;
    logic                        h_re;
    logic [ADDR_W-1:0]           h_raddr;
    logic [HW-1:0]               new_h;
    logic [SLOT_W-1:0]           pos_plus1;
    logic [CMP_W-1:0]            eff_cols;
    logic                        in_row;
    logic [HW-1:0]               h_cur;
    logic [SLOT_W-1:0]           span;
    logic [CAP_W-1:0]            prod_ext;
    logic [mrbm_pkg::AREA_W-1:0] area_sat;

    // Height update: clear on a zero, count up to the cap on a one
    assign new_h = !bit_reg ? '0 :
                   (h_rdata_reg < HW'(MAX_ROWS)) ? h_rdata_reg + HW'(1) : h_rdata_reg;

    assign pos_plus1 = SLOT_W'(pos_reg) + SLOT_W'(1);

    always_comb
    begin
        if (cols_reg == '0)
        begin
            eff_cols = CMP_W'(1);
        end
        else if (CMP_W'(cols_reg) > CMP_W'(MAX_COLS))
        begin
            eff_cols = CMP_W'(MAX_COLS);
        end
        else
        begin
            eff_cols = CMP_W'(cols_reg);
        end
    end

    assign in_row   = (i_reg <= n_reg);
    assign h_cur    = in_row ? h_rdata_reg : '0;
    assign span     = i_reg - s_rdata_reg.idx - SLOT_W'(1);
    assign prod_ext = CAP_W'(prod_reg);
    assign area_sat = (prod_ext > CAP_W'(mrbm_pkg::AREA_CAP)) ? mrbm_pkg::AREA_CAP
                                                             : prod_ext[mrbm_pkg::AREA_W-1:0];

    // Height memory port control
    always_comb
    begin
        h_we    = cmd.clr_step || cmd.cell_upd;
        h_waddr = cmd.clr_step ? clr_cnt_reg : pos_reg;
        h_wdata = cmd.clr_step ? '0 : new_h;
        h_re    = cmd.cell_take || (cmd.scan_rd && in_row);
        h_raddr = cmd.cell_take ? pos_reg : ADDR_W'(i_reg - SLOT_W'(1));
    end

    always_ff @(posedge clk)
    begin
        if (h_we)
        begin
            hmem[h_waddr] <= h_wdata;
        end
        if (h_re)
        begin
            h_rdata_reg <= hmem[h_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            smem[sp_reg[ADDR_W-1:0]] <= top_reg;
        end
        if (cmd.pop_start)
        begin
            s_rdata_reg <= smem[ADDR_W'(sp_reg - SLOT_W'(1))];
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.scan_start)
        begin
            top_reg <= '{idx: '0, h: '0};
        end
        else if (cmd.push)
        begin
            top_reg <= '{idx: i_reg, h: h_cur};
        end
        else if (cmd.pop_load)
        begin
            top_reg <= s_rdata_reg;
        end
        if (cmd.pop_start)
        begin
            peak_h_reg <= top_reg.h;
        end
        if (cmd.pop_load)
        begin
            prod_reg <= PROD_W'(peak_h_reg) * PROD_W'(span);
        end
        if (cmd.out_load)
        begin
            out_area_reg <= best_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg     <= mrbm_pkg::NUM_COLUMNS_RST;
            pos_reg      <= '0;
            clr_cnt_reg  <= '0;
            bit_reg      <= 1'b0;
            last_reg     <= 1'b0;
            n_reg        <= '0;
            i_reg        <= '0;
            sp_reg       <= '0;
            prod_vld_reg <= 1'b0;
            best_reg     <= '0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                cols_reg <= cfg_wdata;
            end

            if (cmd.clr_step)
            begin
                clr_cnt_reg <= sts.clr_done ? '0 : clr_cnt_reg + ADDR_W'(1);
            end

            if (cmd.cell_take)
            begin
                bit_reg  <= in_bit;
                last_reg <= in_last;
            end

            if (cmd.scan_start)
            begin
                n_reg   <= pos_plus1;
                pos_reg <= '0;
                i_reg   <= SLOT_W'(1);
                sp_reg  <= '0;
            end
            else if (cmd.cell_upd)
            begin
                pos_reg <= pos_reg + ADDR_W'(1);
            end
            else if (cmd.push)
            begin
                sp_reg <= sp_reg + SLOT_W'(1);
                i_reg  <= i_reg + SLOT_W'(1);
            end
            else if (cmd.pop_load)
            begin
                sp_reg <= sp_reg - SLOT_W'(1);
            end

            prod_vld_reg <= cmd.pop_load;

            if (cmd.out_load)
            begin
                best_reg <= '0;
            end
            else if (prod_vld_reg && (area_sat > best_reg))
            begin
                best_reg <= area_sat;
            end

            if (cmd.out_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        sts.clr_done   = (clr_cnt_reg == ADDR_W'(MAX_COLS - 1));
        sts.row_close  = (CMP_W'(pos_plus1) >= eff_cols) || last_reg;
        sts.last       = last_reg;
        sts.less       = (h_cur < top_reg.h);
        sts.final_slot = (i_reg == n_reg + SLOT_W'(1));
        sts.out_free   = !out_vld_reg || m_tready;
    end

    assign out_vld  = out_vld_reg;
    assign out_area = out_area_reg;

    // The left sentinel is never popped
    a_pop_has_below: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop_start |-> (sp_reg != '0))
        else $error("pop with nothing below the top of stack");

    // Pushes stop at the last real column
    a_push_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> (i_reg <= n_reg))
        else $error("push beyond the row");

    a_height_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cell_upd |-> (new_h <= HW'(MAX_ROWS)))
        else $error("column height above cap");

    a_best_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> (best_reg == '0))
        else $error("best area not cleared after result");

endmodule

>>> sim/tb_maximal_rectangle_binary_matrix.sv
`timescale 1ns / 1ps

module tb_maximal_rectangle_binary_matrix;

    localparam int MAX_COLS       = mrbm_pkg::MAX_COLS_DEF;
    localparam int MAX_ROWS       = mrbm_pkg::MAX_ROWS_DEF;
    // Worst row scan, the clearing sweep and some margin
    localparam int SETTLE_CYCLES  = 4 * MAX_COLS + 2 + MAX_COLS + 32;
    // Longest legal stretch with no item moving is the settle pause plus stalls
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int ITEMS_PER_PHASE = 220;

    logic                             clk       = 1'b0;
    logic                             rst_n     = 1'b0;
    logic                             cfg_wen   = 1'b0;
    logic [mrbm_pkg::CFG_W-1:0]       cfg_wdata = '0;
    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    logic [7:0]                       s_tdata   = '0;     // [0] cell_bit, [7:1] zero
    logic                             s_tlast   = 1'b0;   // matrix_end
    logic                             m_tvalid;
    logic                             m_tready  = 1'b0;
    logic [15:0]                      m_tdata;            // [14:0] max_area, [15] zero

    // Idle and stall rates in percent, changed per phase
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int errors         = 0;
    int stalled_cycles = 0;
    int cells_sent     = 0;

    // Mirror of the block: column count register, running heights, row
    // position and best area of the matrix in progress
    logic [mrbm_pkg::CFG_W-1:0]  col_count_reg = mrbm_pkg::NUM_COLUMNS_RST;
    logic [8:0]                  col_height [MAX_COLS];
    int                          col_pos   = 0;
    int                          best_area = 0;
    logic [mrbm_pkg::AREA_W-1:0] expected_areas [$];
    logic [mrbm_pkg::AREA_W-1:0] area_want;

    maximal_rectangle_binary_matrix i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Effective column count: zero acts as one, large values clamp
    function automatic int active_columns();
        if (col_count_reg == 0)
            return 1;
        if (col_count_reg > MAX_COLS)
            return MAX_COLS;
        return int'(col_count_reg);
    endfunction

    // Largest rectangle under the histogram of the first n columns: grow each
    // bar left and right while neighbors are at least as tall
    function automatic int largest_in_row(int n);
        int best;
        int h;
        int l;
        int r;
        int area;
        best = 0;
        for (int i = 0; i < n; i++)
        begin
            h = col_height[i];
            if (h == 0)
                continue;
            l = i;
            while (l > 0 && col_height[l-1] >= h)
                l--;
            r = i;
            while (r < n - 1 && col_height[r+1] >= h)
                r++;
            area = h * (r - l + 1);
            if (area > int'(mrbm_pkg::AREA_CAP))
                area = int'(mrbm_pkg::AREA_CAP);
            if (area > best)
                best = area;
        end
        return best;
    endfunction

    function automatic void clear_matrix();
        foreach (col_height[i])
            col_height[i] = '0;
        col_pos   = 0;
        best_area = 0;
    endfunction

    // Advance the mirror by one accepted cell; queue the area on matrix end
    function automatic void track_cell(bit cell_val, bit last);
        int cols;
        int pos;
        int row_area;
        cols = active_columns();
        pos  = col_pos % MAX_COLS;
        if (!cell_val)
            col_height[pos] = '0;
        else if (col_height[pos] < MAX_ROWS)
            col_height[pos] = col_height[pos] + 1'b1;
        col_pos = pos + 1;
        if (col_pos >= cols || last)
        begin
            row_area = largest_in_row(col_pos);
            if (row_area > best_area)
                best_area = row_area;
            col_pos = 0;
        end
        if (last)
        begin
            expected_areas.push_back(best_area[mrbm_pkg::AREA_W-1:0]);
            clear_matrix();
        end
    endfunction

    task automatic report_mismatch(string msg);
        $display("ERROR @%0t: %s", $time, msg);
        errors++;
    endtask

    // Send one cell; valid stays high after the handshake so that a following
    // item goes out back to back, callers drop it when the stream pauses
    task automatic send_cell(bit cell_val, bit last);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, cell_val};
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        track_cell(cell_val, last);
        cells_sent++;
    endtask

    // Drop valid, wait for every pending area, then let the block finish any
    // scan or clearing sweep still under way
    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_areas.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_column_count(logic [mrbm_pkg::CFG_W-1:0] value);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wen <= 1'b0;
        col_count_reg = value;
        @(posedge clk);
    endtask

    task automatic send_pattern(bit cells [], bit end_on_last);
        foreach (cells[i])
            send_cell(cells[i], end_on_last && (i == cells.size() - 1));
    endtask

    // Receiver side: stall at the phase rate
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= sink_stall_pct);

    // Compare each accepted area with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_areas.size() == 0)
                report_mismatch($sformatf("area %0d with none expected", m_tdata[14:0]));
            else
            begin
                area_want = expected_areas.pop_front();
                if (m_tdata[14:0] !== area_want)
                    report_mismatch($sformatf("max_area %0d, want %0d",
                                              m_tdata[14:0], area_want));
                if (m_tdata[15] !== 1'b0)
                    report_mismatch("m_tdata pad bit set");
            end
        end
    end

    // Hold the run to a bound: end it when nothing moves for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stalled_cycles = 0;
        else
            stalled_cycles++;
        if (stalled_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Matrices of one cell: areas zero and one, with the reset column count
    task automatic test_single_cell_matrices();
        send_cell(1'b0, 1'b1);
        send_cell(1'b1, 1'b1);
        settle();
    endtask

    // Matrix end inside a row: only the columns seen so far form that row
    task automatic test_partial_last_row();
        send_pattern('{1, 1, 1, 0, 1}, 1'b1);
        settle();
    endtask

    // Zero acts as one column, 127 clamps to the maximum, then a narrow grid
    task automatic test_column_count_extremes();
        write_column_count(7'd0);
        send_pattern('{1, 1, 0, 1}, 1'b1);
        settle();
        write_column_count(7'd127);
        send_pattern('{1, 0, 1}, 1'b1);
        settle();
        write_column_count(7'd2);
        send_pattern('{1, 1, 1, 1, 0, 1}, 1'b1);
        settle();
    endtask

    // Count lowered below the current position: the next cell closes the row
    task automatic test_columns_lowered_mid_row();
        write_column_count(7'd6);
        send_pattern('{1, 1, 1, 1, 1}, 1'b0);
        settle();
        write_column_count(7'd3);
        send_cell(1'b1, 1'b0);
        send_pattern('{1, 1, 1}, 1'b1);
        settle();
    endtask

    // A single column of ones taller than the height limit
    task automatic test_height_saturation();
        write_column_count(7'd1);
        for (int k = 0; k < MAX_ROWS + 44; k++)
            send_cell(1'b1, k == MAX_ROWS + 43);
        settle();
    endtask

    function automatic logic [mrbm_pkg::CFG_W-1:0] pick_column_count();
        int r;
        r = $urandom_range(99);
        if (r < 6)
            return 7'd0;
        if (r < 9)
            return 7'd127;
        if (r < 12)
            return 7'($urandom_range(MAX_COLS + 1, 126));
        if (r < 17)
            return 7'(MAX_COLS);
        if (r < 25)
            return 7'($urandom_range(9, MAX_COLS - 1));
        return 7'($urandom_range(1, 8));
    endfunction

    // Whole matrices with random content; some end inside the last row
    task automatic send_random_matrix();
        int cols;
        int rows;
        int total;
        int density;
        int r;
        cols  = active_columns();
        rows  = (cols > 16) ? $urandom_range(1, 2) : $urandom_range(1, 8);
        total = rows * cols;
        if ($urandom_range(4) == 0)
            total = total - $urandom_range(0, cols - 1);
        r = $urandom_range(3);
        density = (r == 0) ? 50 : (r == 1) ? 75 : (r == 2) ? 90 : 100;
        for (int k = 0; k < total; k++)
            send_cell($urandom_range(99) < density, k == total - 1);
    endtask

    task automatic test_random_matrices(int idle_pct, int stall_pct);
        int phase_end;
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        phase_end      = cells_sent + ITEMS_PER_PHASE;
        settle();
        write_column_count(pick_column_count());
        while (cells_sent < phase_end)
        begin
            // Reconfigure now and then; otherwise stream matrices back to back
            if ($urandom_range(2) == 0)
            begin
                settle();
                write_column_count(pick_column_count());
            end
            send_random_matrix();
        end
        settle();
    endtask

    initial
    begin
        clear_matrix();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        test_single_cell_matrices();
        test_partial_last_row();
        test_column_count_extremes();
        test_columns_lowered_mid_row();
        test_height_saturation();
        test_random_matrices(0, 0);
        test_random_matrices(57, 0);
        test_random_matrices(0, 57);
        test_random_matrices(19, 19);

        settle();
        if (errors == 0 && expected_areas.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> files.f
rtl/mrbm_pkg.sv
rtl/mrbm_ctrl.sv
rtl/mrbm_dpath.sv
rtl/maximal_rectangle_binary_matrix.sv
sim/tb_maximal_rectangle_binary_matrix.sv
